FILE: hdl/gdts_pkg.sv
// Shared item types and status types for the graph degree and triangle statistics block.
package gdts_pkg;

  // One adjacency row as it arrives on the input channel.
  typedef struct packed {
    logic [5:0]  row_index;
    logic [63:0] neighbor_mask;
    logic        last_row;
  } gdts_in_t;

  // One statistics result as it leaves on the output channel.
  typedef struct packed {
    logic [6:0]  vertex_total;
    logic [6:0]  min_degree;
    logic [6:0]  max_degree;
    logic [12:0] degree_sum;
    logic [18:0] degree_square_sum;
    logic [22:0] mean_degree_q16;
    logic [28:0] mean_degree_square_q16;
    logic [16:0] open_wedges;
    logic [15:0] triangle_count;
    logic [1:0]  triangle_remainder;
  } gdts_out_t;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } gdts_div_sts_t;

endpackage

FILE: hdl/gdts_div.sv
// Restoring divider that produces one quotient bit per cycle.
module gdts_div #(
  parameter int DVW = 32,
  parameter int NW  = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DVW-1:0]         dividend_i,
  input  logic [NW-1:0]          divisor_i,
  output logic [DVW-1:0]         quotient_o,
  output gdts_pkg::gdts_div_sts_t sts_o
);
  import gdts_pkg::*;

  localparam int CW = $clog2(DVW + 1);

  logic [DVW-1:0] quo_q, quo_d;
  logic [NW-1:0]  rem_q, rem_d;
  logic [NW-1:0]  dvs_q, dvs_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [NW:0]    trial;
  logic [NW:0]    diff;
  logic           fits;

  // Trial subtraction of the divisor from the partial remainder.
  assign trial = {rem_q, quo_q[DVW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  // Next-state logic: load on start, then shift one bit per cycle.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(DVW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[NW-1:0] : trial[NW-1:0];
      quo_d = {quo_q[DVW-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the data path is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;

endmodule

FILE: hdl/graph_degree_triangle_stats_core.sv
// Top level of the graph degree and triangle statistics block.
//
// Adjacency rows are written into an internal row memory at one item per cycle when
// idle. The item marked as the last row starts a walk over the first vertex_count
// vertices: each vertex has four steps (row read, degree count, statistics update,
// neighbour check) plus a fetch and a pair-count step for every neighbour, because the
// single read port of the row memory fetches one neighbour row at a time for the pair
// count. As the walk ends, the pair count is split by three with a reciprocal
// multiplication. The two remaining quotients (mean degree and mean squared degree) go
// in turn through one shared restoring divider, whose dividend width DVW is derived from
// MAX_VERTICES and FRAC_BITS (35 at the defaults). No further item is accepted until the
// result is loaded into the output register; rows may be loaded again while that result
// waits, but a new last row waits until it is taken. The row memory is not cleared.
module graph_degree_triangle_stats_core #(
  parameter int MAX_VERTICES = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gdts_pkg::gdts_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gdts_pkg::gdts_out_t out_item_o
);
  import gdts_pkg::*;

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int DSW = $clog2(MAX_VERTICES * 64 + 1);
  localparam int DQW = $clog2(MAX_VERTICES * 4096 + 1);
  localparam int PW  = $clog2(MAX_VERTICES * 2016 + 1);
  localparam int DVW = (DQW + FRAC_BITS > 29) ? (DQW + FRAC_BITS) : 29;
  localparam int TK  = PW + 1;

  localparam logic [8:0]    MaxVert  = 9'(MAX_VERTICES);
  // Rounded-up reciprocal of three, scaled by 2^TK.
  localparam logic [TK-1:0] TriRecip = TK'((2 ** TK + 2) / 3);

  // Sequencer states.
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RDV  = 3'd1;
  localparam logic [2:0] S_DEG  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_NB   = 3'd4;
  localparam logic [2:0] S_PC   = 3'd5;
  localparam logic [2:0] S_DIVS = 3'd6;
  localparam logic [2:0] S_DIVW = 3'd7;

  // Order of the divisions.
  localparam logic DIV_MEAN = 1'b0;
  localparam logic DIV_MSQ  = 1'b1;

  // Bit count of a 64-bit word, byte by byte and then over the bytes.
  function automatic logic [6:0] popcount64(input logic [63:0] x);
    logic [3:0] part [8];
    logic [6:0] total;
    total = '0;
    for (int b = 0; b < 8; b++) begin
      part[b] = '0;
      for (int k = 0; k < 8; k++) begin
        part[b] = part[b] + 4'(x[8*b+k]);
      end
      total = total + 7'(part[b]);
    end
    return total;
  endfunction

  logic [63:0]   mem [MAX_VERTICES];
  logic [63:0]   rd_row_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [2:0]     state_q, state_d;
  logic [6:0]     vcount_q;
  logic [NW-1:0]  n_q, n_d;
  logic [63:0]    mask_q, mask_d;
  logic [AW-1:0]  v_q, v_d;
  logic [63:0]    rest_q, rest_d;
  logic [6:0]     deg_q, deg_d;
  logic [6:0]     dmin_q, dmin_d;
  logic [6:0]     dmax_q, dmax_d;
  logic [DSW-1:0] dsum_q, dsum_d;
  logic [DQW-1:0] dsq_q, dsq_d;
  logic [PW-1:0]  wedge_q, wedge_d;
  logic [PW-1:0]  pairs_q, pairs_d;
  logic           div_idx_q, div_idx_d;
  logic           out_valid_q, out_valid_d;
  gdts_out_t      out_q, out_d;

  logic          in_acc;
  logic [8:0]    cnt_ext;
  logic [8:0]    n_sel;
  logic [63:0]   low_bit;
  logic [5:0]    nb_idx;
  logic [13:0]   deg_sq;
  logic [13:0]   wedge_inc;
  logic          last_vertex;

  logic [PW+TK-1:0] tri_prod;
  logic [PW-1:0]    tri_quo;
  logic [1:0]       tri_rem;

  logic                div_start;
  logic [DVW-1:0]      div_dividend;
  logic [NW-1:0]       div_divisor;
  logic [DVW-1:0]      div_quo;
  gdts_div_sts_t       div_sts;

  // A last row may not enter while an earlier result still waits.
  assign in_ready_o = (state_q == S_LOAD) && !(out_valid_q && in_item_i.last_row);
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_en      = in_acc && ({3'b000, in_item_i.row_index} < MaxVert);

  // Effective vertex count and the mask of usable neighbour bits.
  assign cnt_ext = {2'b00, vcount_q};
  always_comb begin
    if (cnt_ext == 9'd0) begin
      n_sel = 9'd1;
    end else if (cnt_ext > MaxVert) begin
      n_sel = MaxVert;
    end else begin
      n_sel = cnt_ext;
    end
  end

  // Lowest remaining neighbour of the current vertex.
  assign low_bit = rest_q & (~rest_q + 64'd1);
  always_comb begin
    nb_idx = '0;
    for (int k = 0; k < 64; k++) begin
      if (low_bit[k]) begin
        nb_idx = nb_idx | 6'(k);
      end
    end
  end

  // Square of the degree and its wedge contribution, d(d-1)/2.
  assign deg_sq      = 14'(deg_q) * 14'(deg_q);
  assign wedge_inc   = (deg_sq - 14'(deg_q)) >> 1;
  assign last_vertex = (v_q == AW'(n_q - NW'(1)));

  // Pair count over three by reciprocal multiplication; exact for every count in PW bits.
  assign tri_prod = (PW + TK)'(pairs_q) * (PW + TK)'(TriRecip);
  assign tri_quo  = tri_prod[PW+TK-1:TK];
  assign tri_rem  = 2'(pairs_q - tri_quo - (tri_quo << 1));

  // Operands of the shared divider.
  assign div_divisor = n_q;
  always_comb begin
    unique case (div_idx_q)
      DIV_MEAN: div_dividend = DVW'(dsum_q) << FRAC_BITS;
      DIV_MSQ:  div_dividend = DVW'(dsq_q) << FRAC_BITS;
    endcase
  end

  // Sequencer and statistics data path.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    mask_d      = mask_q;
    v_d         = v_q;
    rest_d      = rest_q;
    deg_d       = deg_q;
    dmin_d      = dmin_q;
    dmax_d      = dmax_q;
    dsum_d      = dsum_q;
    dsq_d       = dsq_q;
    wedge_d     = wedge_q;
    pairs_d     = pairs_q;
    div_idx_d   = div_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = v_q;
    div_start   = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc && in_item_i.last_row) begin
          n_d     = NW'(n_sel);
          mask_d  = (n_sel >= 9'd64) ? '1 : ((64'd1 << n_sel) - 64'd1);
          v_d     = '0;
          dmin_d  = 7'd64;
          dmax_d  = '0;
          dsum_d  = '0;
          dsq_d   = '0;
          wedge_d = '0;
          pairs_d = '0;
          state_d = S_RDV;
        end
      end
      S_RDV: begin
        rd_en   = 1'b1;
        rd_addr = v_q;
        state_d = S_DEG;
      end
      S_DEG: begin
        rest_d  = rd_row_q & mask_q;
        deg_d   = popcount64(rd_row_q & mask_q);
        state_d = S_ACC;
      end
      S_ACC: begin
        if (deg_q < dmin_q) begin
          dmin_d = deg_q;
        end
        if (deg_q > dmax_q) begin
          dmax_d = deg_q;
        end
        dsum_d  = dsum_q + DSW'(deg_q);
        dsq_d   = dsq_q + DQW'(deg_sq);
        wedge_d = wedge_q + PW'(wedge_inc);
        state_d = S_NB;
      end
      S_NB: begin
        if (rest_q != 64'd0) begin
          // Fetch the row of the lowest neighbour and drop it from the set.
          rd_en   = 1'b1;
          rd_addr = AW'(nb_idx);
          rest_d  = rest_q & (rest_q - 64'd1);
          state_d = S_PC;
        end else if (last_vertex) begin
          out_d.vertex_total       = 7'(n_q);
          out_d.min_degree         = dmin_q;
          out_d.max_degree         = dmax_q;
          out_d.degree_sum         = 13'(dsum_q);
          out_d.degree_square_sum  = 19'(dsq_q);
          out_d.open_wedges        = 17'(wedge_q);
          out_d.triangle_count     = 16'(tri_quo);
          out_d.triangle_remainder = tri_rem;
          div_idx_d                = DIV_MEAN;
          state_d                  = S_DIVS;
        end else begin
          v_d     = v_q + AW'(1);
          state_d = S_RDV;
        end
      end
      S_PC: begin
        // Higher neighbours that are also adjacent to the fetched neighbour.
        pairs_d = pairs_q + PW'(popcount64(rest_q & rd_row_q & mask_q));
        state_d = S_NB;
      end
      S_DIVS: begin
        div_start = 1'b1;
        state_d   = S_DIVW;
      end
      S_DIVW: begin
        if (div_sts.done) begin
          unique case (div_idx_q)
            DIV_MEAN: begin
              out_d.mean_degree_q16 = 23'(div_quo);
              div_idx_d             = DIV_MSQ;
              state_d               = S_DIVS;
            end
            DIV_MSQ: begin
              out_d.mean_degree_square_q16 = 29'(div_quo);
              out_valid_d                  = 1'b1;
              state_d                      = S_LOAD;
            end
          endcase
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      vcount_q    <= 7'd64;
      out_valid_q <= 1'b0;
      div_idx_q   <= DIV_MEAN;
      v_q         <= '0;
      n_q         <= NW'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      div_idx_q   <= div_idx_d;
      v_q         <= v_d;
      n_q         <= n_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    rest_q  <= rest_d;
    deg_q   <= deg_d;
    dmin_q  <= dmin_d;
    dmax_q  <= dmax_d;
    dsum_q  <= dsum_d;
    dsq_q   <= dsq_d;
    wedge_q <= wedge_d;
    pairs_q <= pairs_d;
    out_q   <= out_d;
  end

  // Row memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AW'(in_item_i.row_index)] <= in_item_i.neighbor_mask;
    end
    if (rd_en) begin
      rd_row_q <= mem[rd_addr];
    end
  end

  gdts_div #(
    .DVW(DVW),
    .NW (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .sts_o      (div_sts)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // No result can be pending while the statistics are being worked out.
  a_no_result_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> !out_valid_q)
    else $error("result pending during the walk");

  // A last row starts the walk with the read of the first row.
  a_last_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_item_i.last_row) |=> (state_q == S_RDV))
    else $error("last row did not start the walk");

  // The vertex counter stays below the effective vertex count.
  a_vertex_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> ({1'b0, v_q} < {1'b0, n_q}))
    else $error("vertex counter beyond vertex count");

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the graph degree and triangle statistics core.
`timescale 1ns / 100ps

module tb_top;
  import gdts_pkg::*;

  localparam int unsigned NUM_VERTICES  = 64;
  localparam int unsigned FRAC_SHIFT    = 16;
  localparam int unsigned RANDOM_ITEMS  = 950;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned WALK_CYCLES   = 9000;
  localparam int unsigned MAX_PRINTED   = 100;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [6:0] cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  gdts_in_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  gdts_out_t out_item_o;

  // Local copy of the row memory and the vertex count register.
  logic [63:0] shadow_rows [NUM_VERTICES];
  logic [6:0]  shadow_count;
  gdts_out_t   expected_stats [$];
  int unsigned fail_count;
  int unsigned result_count;
  int unsigned items_sent;
  bit          calm;

  graph_degree_triangle_stats_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Generous limit on the whole run.
  initial begin
    #200_000_000;
    $display("graph_degree_triangle_stats_core: mismatch");
    $finish;
  end

  // The register value as the block uses it: zero acts as one, large values clamp.
  function automatic int unsigned effective_n(logic [6:0] c);
    if (c == 7'd0) return 1;
    if (32'(c) > NUM_VERTICES) return NUM_VERTICES;
    return 32'(c);
  endfunction

  // Degree and triangle statistics of the graph currently held in the row copy.
  function automatic gdts_out_t graph_stats();
    int unsigned n, d, dmin, dmax;
    int v, i;
    longint unsigned dsum, dsq, wedges, pairs;
    logic [63:0] valid_m, row, above;
    gdts_out_t s;
    n = effective_n(shadow_count);
    valid_m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    dmin = 64;
    dmax = 0;
    dsum = 0;
    dsq = 0;
    wedges = 0;
    pairs = 0;
    for (v = 0; v < n; v++) begin
      row = shadow_rows[v] & valid_m;
      d = $countones(row);
      if (d < dmin) dmin = d;
      if (d > dmax) dmax = d;
      dsum += d;
      dsq += d * d;
      if (d > 0) wedges += d * (d - 1) / 2;
      // Each neighbour i is paired with every higher neighbour that i also sees.
      for (i = 0; i < 64; i++) begin
        if (row[i]) begin
          above = ~((64'd2 << i) - 64'd1);
          pairs += $countones(row & above & shadow_rows[i] & valid_m);
        end
      end
    end
    if (dmin > dmax) dmin = dmax;
    s.vertex_total           = 7'(n);
    s.min_degree             = 7'(dmin);
    s.max_degree             = 7'(dmax);
    s.degree_sum             = 13'(dsum);
    s.degree_square_sum      = 19'(dsq);
    s.mean_degree_q16        = 23'((dsum << FRAC_SHIFT) / n);
    s.mean_degree_square_q16 = 29'((dsq << FRAC_SHIFT) / n);
    s.open_wedges            = 17'(wedges);
    s.triangle_count         = 16'(pairs / 3);
    s.triangle_remainder     = 2'(pairs % 3);
    return s;
  endfunction

  // Prints one line per mismatch, up to a limit, and counts them all.
  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
  endtask

  task automatic compare_stats(input gdts_out_t got, input gdts_out_t want);
    check_field("vertex_total", 32'(got.vertex_total), 32'(want.vertex_total));
    check_field("min_degree", 32'(got.min_degree), 32'(want.min_degree));
    check_field("max_degree", 32'(got.max_degree), 32'(want.max_degree));
    check_field("degree_sum", 32'(got.degree_sum), 32'(want.degree_sum));
    check_field("degree_square_sum", 32'(got.degree_square_sum),
                32'(want.degree_square_sum));
    check_field("mean_degree_q16", 32'(got.mean_degree_q16), 32'(want.mean_degree_q16));
    check_field("mean_degree_square_q16", 32'(got.mean_degree_square_q16),
                32'(want.mean_degree_square_q16));
    check_field("open_wedges", 32'(got.open_wedges), 32'(want.open_wedges));
    check_field("triangle_count", 32'(got.triangle_count), 32'(want.triangle_count));
    check_field("triangle_remainder", 32'(got.triangle_remainder),
                32'(want.triangle_remainder));
  endtask

  // Tracks accepted rows and checks each accepted result against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    gdts_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_stats.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", result_count));
        end else begin
          want = expected_stats.pop_front();
          compare_stats(out_item_o, want);
        end
        result_count++;
      end
      if (in_valid_i && in_ready_o) begin
        shadow_rows[in_item_i.row_index] = in_item_i.neighbor_mask;
        if (in_item_i.last_row) expected_stats.insert(expected_stats.size(), graph_stats());
        items_sent++;
      end
    end
  end

  // Mostly short gaps, now and then a long one, none at all in calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result channel back-pressure.
  initial begin : result_stall
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  // Offers one row item; entered and left at a falling edge. Valid is left high only
  // when another item follows at once.
  task automatic send_row(input logic [5:0] r, input logic [63:0] mask, input logic last);
    gdts_in_t item;
    int unsigned gap;
    item.row_index = r;
    item.neighbor_mask = mask;
    item.last_row = last;
    in_item_i <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Stops offering rows and waits until every expected result has been taken.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes the vertex count once the block is idle.
  task automatic set_count(input logic [6:0] c);
    wait_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c;
    shadow_count = c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [6:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 14) return 7'd1;
    if (r < 60) return 7'($urandom_range(2, 8));
    if (r < 80) return 7'($urandom_range(9, 24));
    if (r < 88) return 7'($urandom_range(25, 63));
    if (r < 94) return 7'd64;
    return 7'($urandom_range(65, 127));
  endfunction

  // Complete 64-vertex graph with self loops at the reset vertex count: every field
  // but the remainder at its maximum, and every row written before any walk reads it.
  task automatic test_full_graph_default();
    int r;
    for (r = 0; r < 64; r++) send_row(6'(r), '1, r == 63);
  endtask

  // Count register extremes: zero and values above the maximum clamp.
  task automatic test_count_limits();
    set_count(7'd0);
    send_row(6'd0, '1, 1'b1);
    set_count(7'd127);
    send_row(6'd5, 64'd0, 1'b1);
    set_count(7'd65);
    send_row(6'd5, 64'hAAAA_5555_F0F0_0F0F, 1'b1);
    // A last mark on a row outside the graph still yields a result.
    set_count(7'd1);
    send_row(6'd63, '1, 1'b1);
  endtask

  // Graph with no edges at all.
  task automatic test_empty_graph();
    int r;
    set_count(7'd4);
    for (r = 0; r < 4; r++) send_row(6'(r), 64'd0, r == 3);
  endtask

  // One-sided rows leave a remainder of one or two; self loops pair like any neighbour.
  task automatic test_asymmetric_rows();
    set_count(7'd3);
    send_row(6'd0, 64'b110, 1'b0);
    send_row(6'd1, 64'b100, 1'b0);
    send_row(6'd2, 64'd0, 1'b1);
    set_count(7'd4);
    send_row(6'd0, 64'b1110, 1'b0);
    send_row(6'd1, 64'b1100, 1'b0);
    send_row(6'd2, 64'd0, 1'b0);
    send_row(6'd3, 64'd0, 1'b1);
    set_count(7'd3);
    send_row(6'd0, 64'b011, 1'b0);
    send_row(6'd1, 64'b011, 1'b0);
    send_row(6'd2, 64'd0, 1'b1);
  endtask

  // Complete graph on eight vertices with junk above the vertex count and in rows
  // beyond it, all of which must be ignored.
  task automatic test_ignored_bits();
    int r;
    set_count(7'd8);
    for (r = 0; r < 8; r++)
      send_row(6'(r), {{$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00} |
                      64'(8'hFF & ~(8'd1 << r)), 1'b0);
    send_row(6'd40, {$urandom, $urandom}, 1'b0);
    send_row(6'd50, '1, 1'b1);
  endtask

  // Random graphs loaded in random order, with partial updates and stray rows.
  task automatic test_random_graphs();
    logic [63:0] graph [NUM_VERTICES];
    int order [NUM_VERTICES];
    int n, k, j, v, tmp;
    int unsigned density, kind, start_items;
    bit symmetric, loops;
    logic [63:0] valid_m;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) set_count(pick_count());
      n = effective_n(shadow_count);
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // Well-formed load of rows 0 to n-1; the final row carries the last mark.
        case ($urandom_range(0, 5))
          0: density = 0;
          1: density = 10;
          2: density = 30;
          3: density = 50;
          4: density = 80;
          default: density = 100;
        endcase
        symmetric = ($urandom_range(0, 99) < 85);
        loops = ($urandom_range(0, 99) < 15);
        valid_m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        for (v = 0; v < n; v++) graph[v] = {$urandom, $urandom} & ~valid_m;
        for (v = 0; v < n; v++) begin
          for (j = 0; j < n; j++) begin
            if (j == v) begin
              if (loops && $urandom_range(0, 1) == 1) graph[v][j] = 1'b1;
            end else if (!symmetric || j > v) begin
              if ($urandom_range(0, 99) < density) begin
                graph[v][j] = 1'b1;
                if (symmetric) graph[j][v] = 1'b1;
              end
            end
          end
        end
        for (k = 0; k < n; k++) order[k] = k;
        for (k = n - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (k = 0; k < n; k++) begin
          if (n < 64 && $urandom_range(0, 9) == 0)
            send_row(6'($urandom_range(n, 63)), {$urandom, $urandom}, 1'b0);
          send_row(6'(order[k]), graph[order[k]], k == n - 1);
        end
      end else if (kind < 92) begin
        // A few rows rewritten, then a result over the updated graph.
        k = $urandom_range(1, 4);
        for (j = 0; j < k; j++)
          send_row(6'($urandom_range(0, n - 1)), {$urandom, $urandom}, j == k - 1);
      end else begin
        // Stray rows with no last mark.
        k = $urandom_range(1, 6);
        for (j = 0; j < k; j++)
          send_row(6'($urandom_range(0, 63)), {$urandom, $urandom}, 1'b0);
      end
    end
    calm = 1'b0;
  endtask

  // Reset, then the tests in turn, then the final verdict.
  initial begin
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    calm = 1'b0;
    fail_count = 0;
    result_count = 0;
    items_sent = 0;
    shadow_count = 7'd64;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_full_graph_default();
    test_count_limits();
    test_empty_graph();
    test_asymmetric_rows();
    test_ignored_bits();
    test_random_graphs();
    wait_results();
    // Leave room for a stray result from a spurious walk.
    repeat (WALK_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("graph_degree_triangle_stats_core: match");
    end else begin
      $display("graph_degree_triangle_stats_core: mismatch");
    end
    $finish;
  end

endmodule
